// ----- hw/rtl/can_id_flood_rate_monitor_core_defines.svh -----
// Assertion macros shared by the flood rate monitor checker.
`ifndef CAN_ID_FLOOD_RATE_MONITOR_CORE_DEFINES_SVH
`define CAN_ID_FLOOD_RATE_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CFRM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CFRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cfrm_pkg.sv -----
// Types, constants and helpers shared by the flood rate monitor modules.
package cfrm_pkg;

	localparam int ID_W   = 11;
	localparam int TIME_W = 48;
	localparam int CNT_W  = 17;
	localparam int CFG_W  = 16;
	localparam int WIN_W  = 26;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [WIN_W-1:0] US_PER_MS = 26'd1000;

	// Register reset values.
	localparam logic [CFG_W-1:0] WINDOW_MS_RST     = 16'd1000;
	localparam logic [CFG_W-1:0] PER_ID_THRESH_RST = 16'd100;
	localparam logic [CFG_W-1:0] TOTAL_THRESH_RST  = 16'd1000;

	// Register indexes (word address).
	localparam logic [1:0] REG_WINDOW_MS     = 2'd0;
	localparam logic [1:0] REG_PER_ID_THRESH = 2'd1;
	localparam logic [1:0] REG_TOTAL_THRESH  = 2'd2;

	typedef enum logic [1:0] {
		ALERT_NONE     = 2'd0,
		ALERT_ID_FLOOD = 2'd1,
		ALERT_BUS_SAT  = 2'd2
	} alert_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK,
		ST_UPDATE,
		ST_EMIT
	} eng_state_t;

	// One entry of the slot table.
	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] start;
		logic              alerted;
	} slot_entry_t;

	// Settings seen by the engine.
	typedef struct packed {
		logic [WIN_W-1:0] win_us;
		logic [CFG_W-1:0] per_id_thresh;
		logic [CFG_W-1:0] total_thresh;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		alert_kind_t      kind;
		logic [ID_W-1:0]  ident;
		logic [CNT_W-1:0] count;
	} res_t;

	// Saturating increment of a window count.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ----- hw/rtl/cfrm_slot_ram.sv -----
// Single-port-write, single-port-read slot table RAM with registered read data.
module cfrm_slot_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                  clk,
	input  logic [AW-1:0]         rd_addr,
	output cfrm_pkg::slot_entry_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  cfrm_pkg::slot_entry_t wr_data
);
	import cfrm_pkg::*;

	slot_entry_t mem_q [DEPTH];
	slot_entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, with the read data registered.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/cfrm_cfg_regs.sv -----
// APB-style configuration registers and the derived window length in microseconds.
module cfrm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cfrm_pkg::PADDR_W-1:0]   paddr,
	input  logic [cfrm_pkg::PDATA_W-1:0]   pwdata,
	output logic [cfrm_pkg::PDATA_W-1:0]   prdata,
	output cfrm_pkg::cfg_t                 cfg
);
	import cfrm_pkg::*;

	logic [CFG_W-1:0] window_ms_q;
	logic [CFG_W-1:0] per_id_thresh_q;
	logic [CFG_W-1:0] total_thresh_q;
	logic [WIN_W-1:0] win_us_q;
	logic [1:0]       reg_idx;
	logic             wr_beat;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_beat = psel && penable && pwrite;

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q     <= WINDOW_MS_RST;
			per_id_thresh_q <= PER_ID_THRESH_RST;
			total_thresh_q  <= TOTAL_THRESH_RST;
			win_us_q        <= WIN_W'(WINDOW_MS_RST) * US_PER_MS;
		end else begin
			if (wr_beat) begin
				unique case (reg_idx)
					REG_WINDOW_MS:     window_ms_q     <= pwdata[CFG_W-1:0];
					REG_PER_ID_THRESH: per_id_thresh_q <= pwdata[CFG_W-1:0];
					REG_TOTAL_THRESH:  total_thresh_q  <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			// The window in microseconds follows the millisecond register in the next cycle.
			win_us_q <= WIN_W'(window_ms_q) * US_PER_MS;
		end
	end

	// Read mux.
	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_MS:     prdata = PDATA_W'(window_ms_q);
			REG_PER_ID_THRESH: prdata = PDATA_W'(per_id_thresh_q);
			REG_TOTAL_THRESH:  prdata = PDATA_W'(total_thresh_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.win_us        = win_us_q;
	assign cfg.per_id_thresh = per_id_thresh_q;
	assign cfg.total_thresh  = total_thresh_q;

endmodule

// ----- hw/rtl/cfrm_engine.sv -----
// Frame sequencer: scans the slot RAM, picks a slot, updates windows and raises alerts.
module cfrm_engine #(
	parameter int TABLE_ENTRIES = 32,
	parameter int IDXW          = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfrm_pkg::cfg_t                    cfg,
	input  logic                              frame_valid,
	output logic                              frame_ready,
	input  logic [cfrm_pkg::ID_W-1:0]         frame_ident,
	input  logic [cfrm_pkg::TIME_W-1:0]       arrival_time_us,
	output logic                              res_valid,
	input  logic                              res_ready,
	output cfrm_pkg::res_t                    res,
	output logic [IDXW-1:0]                   rd_addr,
	input  cfrm_pkg::slot_entry_t             rd_data,
	output logic                              wr_en,
	output logic [IDXW-1:0]                   wr_addr,
	output cfrm_pkg::slot_entry_t             wr_data
);
	import cfrm_pkg::*;

	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

	eng_state_t state_q, state_d;
	logic       rd_issue;
	logic       accept;

	// Frame being worked on.
	logic [ID_W-1:0]   ident_q;
	logic [TIME_W-1:0] now_q;

	// Scan bookkeeping.
	logic [IDXW-1:0]          scan_q;
	logic                     rd_vld_s1;
	logic [IDXW-1:0]          rd_idx_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     hit_q, free_q, min_found_q;
	logic [IDXW-1:0]          hit_idx_q, free_idx_q, min_idx_q;
	slot_entry_t              hit_ent_q;
	logic [CNT_W-1:0]         min_cnt_q;
	logic                     rd_valid, slot_hit, min_take;

	// Bus-wide window.
	logic [CNT_W-1:0]  bus_count_q;
	logic [TIME_W-1:0] bus_start_q;
	logic              bus_alerted_q;
	logic              bus_over_q;

	// Selected slot after the window check.
	logic [IDXW-1:0] sel_idx_q, sel_idx_d;
	slot_entry_t     base_q, base_d, cur_ent, fresh_ent;
	logic            slot_over, bus_over_d;

	// Update step.
	logic [CNT_W-1:0] new_cnt, bus_base, bus_new;
	logic             slot_fire, bus_fire, bus_al_base;
	res_t             res_q, res_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshakes.
	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		rd_issue    = 1'b0;
		wr_en       = 1'b0;
		res_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				rd_issue = 1'b1;
				if (scan_q == LAST_IDX) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_CHECK;
			ST_CHECK: state_d = ST_UPDATE;
			ST_UPDATE: begin
				wr_en   = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept  = frame_valid && frame_ready;
	assign rd_addr = scan_q;

	// Evaluate the entry that the RAM returns during the scan.
	assign rd_valid = valid_q[rd_idx_s1];
	assign slot_hit = rd_valid && (rd_data.ident == ident_q);
	assign min_take = rd_valid && (!min_found_q || (rd_data.count < min_cnt_q));

	// Slot choice and window check: hit, else first free slot, else first smallest count.
	always_comb begin
		fresh_ent.ident   = ident_q;
		fresh_ent.count   = '0;
		fresh_ent.start   = now_q;
		fresh_ent.alerted = 1'b0;
		sel_idx_d  = hit_q ? hit_idx_q : (free_q ? free_idx_q : min_idx_q);
		cur_ent    = hit_q ? hit_ent_q : fresh_ent;
		slot_over  = (now_q - cur_ent.start) > TIME_W'(cfg.win_us);
		base_d     = slot_over ? fresh_ent : cur_ent;
		bus_over_d = (now_q - bus_start_q) > TIME_W'(cfg.win_us);
	end

	// Count, alert decision and the write-back entry.
	always_comb begin
		new_cnt     = sat_inc(base_q.count);
		slot_fire   = !base_q.alerted && (new_cnt > CNT_W'(cfg.per_id_thresh));
		bus_base    = bus_over_q ? '0 : bus_count_q;
		bus_al_base = bus_over_q ? 1'b0 : bus_alerted_q;
		bus_new     = sat_inc(bus_base);
		bus_fire    = !slot_fire && !bus_al_base && (bus_new > CNT_W'(cfg.total_thresh));

		wr_addr         = sel_idx_q;
		wr_data.ident   = ident_q;
		wr_data.count   = new_cnt;
		wr_data.start   = base_q.start;
		wr_data.alerted = base_q.alerted || slot_fire;

		if (slot_fire) begin
			res_d.kind  = ALERT_ID_FLOOD;
			res_d.ident = ident_q;
			res_d.count = new_cnt;
		end else if (bus_fire) begin
			res_d.kind  = ALERT_BUS_SAT;
			res_d.ident = ident_q;
			res_d.count = bus_new;
		end else begin
			res_d.kind  = ALERT_NONE;
			res_d.ident = '0;
			res_d.count = '0;
		end
	end

	// Control state: scan flags, valid bits and the bus window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q        <= '0;
			rd_vld_s1     <= 1'b0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			min_found_q   <= 1'b0;
			valid_q       <= '0;
			bus_count_q   <= '0;
			bus_start_q   <= '0;
			bus_alerted_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (accept) begin
				scan_q      <= '0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
				min_found_q <= 1'b0;
			end else if (rd_issue) begin
				scan_q <= scan_q + IDXW'(1);
			end
			if (rd_vld_s1) begin
				if (slot_hit) hit_q <= 1'b1;
				if (!rd_valid) free_q <= 1'b1;
				if (min_take) min_found_q <= 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				valid_q[sel_idx_q] <= 1'b1;
				bus_count_q        <= bus_new;
				bus_alerted_q      <= bus_al_base || bus_fire;
				if (bus_over_q) bus_start_q <= now_q;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ident_q <= frame_ident;
			now_q   <= arrival_time_us;
		end
		rd_idx_s1 <= scan_q;
		if (rd_vld_s1) begin
			if (slot_hit && !hit_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_ent_q <= rd_data;
			end
			if (!rd_valid && !free_q) free_idx_q <= rd_idx_s1;
			if (min_take) begin
				min_idx_q <= rd_idx_s1;
				min_cnt_q <= rd_data.count;
			end
		end
		if (state_q == ST_CHECK) begin
			sel_idx_q  <= sel_idx_d;
			base_q     <= base_d;
			bus_over_q <= bus_over_d;
		end
		if (state_q == ST_UPDATE) res_q <= res_d;
	end

	assign res = res_q;

endmodule

// ----- hw/rtl/can_id_flood_rate_monitor_core.sv -----
// Top level of the CAN identifier flood rate monitor.
//
//  Channel  Handshake                          Payload
//  frame    frame_valid / frame_ready          frame_ident, arrival_time_us
//  alert    alert_valid / alert_ready          alert_kind, alert_ident, alert_count
//  config   psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// A frame runs through the scan of the slot RAM, one entry read per cycle, then the
// drain, check, update and emit steps; the next frame is accepted only after that.
// Reset clears the valid bits, the bus window and the output valid bit at once and
// loads the register defaults; no clearing pass runs.
// The result sits in an output register, so a stalled alert beat holds only the engine
// in its final step; frame_ready stays low from accept until the result is registered.
// The slot write-back ends each frame before the next scan starts, so reads never
// see a stale entry.
module can_id_flood_rate_monitor_core #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              frame_valid,
	output logic                              frame_ready,
	input  logic [cfrm_pkg::ID_W-1:0]         frame_ident,
	input  logic [cfrm_pkg::TIME_W-1:0]       arrival_time_us,
	output logic                              alert_valid,
	input  logic                              alert_ready,
	output logic [1:0]                        alert_kind,
	output logic [cfrm_pkg::ID_W-1:0]         alert_ident,
	output logic [cfrm_pkg::CNT_W-1:0]        alert_count,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cfrm_pkg::PADDR_W-1:0]      paddr,
	input  logic [cfrm_pkg::PDATA_W-1:0]      pwdata,
	output logic [cfrm_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import cfrm_pkg::*;

	localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	cfg_t            cfg;
	logic            res_valid, res_ready;
	res_t            res;
	logic [IDXW-1:0] rd_addr, wr_addr;
	slot_entry_t     rd_data, wr_data;
	logic            wr_en;
	logic            out_valid_q;
	res_t            out_q;

	assign pready = 1'b1;

	cfrm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	cfrm_slot_ram #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDXW)
	) u_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	cfrm_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.IDXW          (IDXW)
	) u_eng (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.frame_valid     (frame_valid),
		.frame_ready     (frame_ready),
		.frame_ident     (frame_ident),
		.arrival_time_us (arrival_time_us),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data)
	);

	// Output register: takes a new beat whenever it is empty or being drained.
	assign res_ready = !out_valid_q || alert_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign alert_valid = out_valid_q;
	assign alert_kind  = out_q.kind;
	assign alert_ident = out_q.ident;
	assign alert_count = out_q.count;

endmodule

// ----- hw/rtl/cfrm_checker.sv -----
// Port-level checker for the flood rate monitor and its bind to the top level.
`include "can_id_flood_rate_monitor_core_defines.svh"

module cfrm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       frame_valid,
	input logic                       frame_ready,
	input logic                       alert_valid,
	input logic                       alert_ready,
	input logic [1:0]                 alert_kind,
	input logic [cfrm_pkg::ID_W-1:0]  alert_ident,
	input logic [cfrm_pkg::CNT_W-1:0] alert_count
);
	import cfrm_pkg::*;

	// Only the three alert codes ever leave the block.
	`CFRM_ASSERT_NOW(a_kind_legal, alert_valid, alert_kind == ALERT_NONE || alert_kind == ALERT_ID_FLOOD || alert_kind == ALERT_BUS_SAT, "alert_kind carries an unknown code")

	// A beat without alert carries no identifier and no count.
	`CFRM_ASSERT_NOW(a_none_zero, alert_valid && alert_kind == ALERT_NONE, alert_ident == '0 && alert_count == '0, "empty alert beat has nonzero fields")

	// A raised alert always reports a count of at least one frame.
	`CFRM_ASSERT_NOW(a_alert_count, alert_valid && alert_kind != ALERT_NONE, alert_count != '0, "alert beat reports a zero count")

	// Frames are taken one at a time: ready drops right after an accept.
	`CFRM_ASSERT_NEXT(a_one_frame, frame_valid && frame_ready, !frame_ready, "frame accepted while another frame is in work")

	// A stalled alert beat stays valid and holds its kind and count.
	`CFRM_ASSERT_NEXT(a_alert_hold, alert_valid && !alert_ready, alert_valid && $stable(alert_kind) && $stable(alert_count), "stalled alert beat changed")

endmodule

bind can_id_flood_rate_monitor_core cfrm_checker u_cfrm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame_valid),
	.frame_ready (frame_ready),
	.alert_valid (alert_valid),
	.alert_ready (alert_ready),
	.alert_kind  (alert_kind),
	.alert_ident (alert_ident),
	.alert_count (alert_count)
);

// ----- sim/flood_alert_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the flood monitor's alert beats from observed frames and compares them.
module flood_alert_checker #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_valid,
	input  logic                          frame_ready,
	input  logic [cfrm_pkg::ID_W-1:0]     frame_ident,
	input  logic [cfrm_pkg::TIME_W-1:0]   arrival_time_us,
	input  logic                          alert_valid,
	input  logic                          alert_ready,
	input  logic [1:0]                    alert_kind,
	input  logic [cfrm_pkg::ID_W-1:0]     alert_ident,
	input  logic [cfrm_pkg::CNT_W-1:0]    alert_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [cfrm_pkg::PADDR_W-1:0]  paddr,
	input  logic [cfrm_pkg::PDATA_W-1:0]  pwdata,
	output int                            fail_count,
	output int                            pending,
	output int                            frames_seen,
	output int                            floods_seen,
	output int                            sats_seen
);
	import cfrm_pkg::*;

	// Shadow copy of the registers.
	logic [CFG_W-1:0] window_ms;
	logic [CFG_W-1:0] id_limit;
	logic [CFG_W-1:0] bus_limit;

	// Shadow copy of the identifier table and the bus window.
	logic              slot_used    [TABLE_ENTRIES];
	logic [ID_W-1:0]   slot_id      [TABLE_ENTRIES];
	logic [CNT_W-1:0]  slot_hits    [TABLE_ENTRIES];
	logic [TIME_W-1:0] slot_opened  [TABLE_ENTRIES];
	logic              slot_flagged [TABLE_ENTRIES];
	logic [CNT_W-1:0]  bus_hits;
	logic [TIME_W-1:0] bus_opened;
	logic              bus_flagged;

	// Alerts predicted for accepted frames, oldest first.
	res_t alert_fifo[$];

	int n_fail = 0;
	int n_frames = 0;
	int n_floods = 0;
	int n_sats = 0;

	assign fail_count  = n_fail;
	assign frames_seen = n_frames;
	assign floods_seen = n_floods;
	assign sats_seen   = n_sats;

	// A window is over once the modular distance from its start exceeds its length.
	function automatic logic window_expired(input logic [TIME_W-1:0] now_us,
			input logic [TIME_W-1:0] opened);
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] elapsed;
		span = TIME_W'(window_ms) * TIME_W'(US_PER_MS);
		elapsed = now_us - opened;
		return elapsed > span;
	endfunction

	// Counts stick at their top value.
	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return c + CNT_W'(c != '1);
	endfunction

	// Work out the alert caused by one frame and queue it.
	task automatic score_frame(input logic [ID_W-1:0] ident, input logic [TIME_W-1:0] now_us);
		int i;
		int s;
		int free_idx;
		res_t want;
		s = -1;
		free_idx = -1;
		if (window_expired(now_us, bus_opened)) begin
			bus_opened = now_us;
			bus_hits = '0;
			bus_flagged = 1'b0;
		end
		bus_hits = count_up(bus_hits);

		// Look up the identifier and note the first free slot on the way.
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (s < 0 && slot_used[i] && slot_id[i] == ident)
				s = i;
			if (free_idx < 0 && !slot_used[i])
				free_idx = i;
		end
		if (s < 0) begin
			if (free_idx >= 0) begin
				s = free_idx;
			end else begin
				// Table full: the first slot with the smallest count gives way.
				s = 0;
				for (i = 1; i < TABLE_ENTRIES; i++)
					if (slot_hits[i] < slot_hits[s])
						s = i;
			end
			slot_used[s] = 1'b1;
			slot_id[s] = ident;
			slot_hits[s] = '0;
			slot_opened[s] = now_us;
			slot_flagged[s] = 1'b0;
		end
		if (window_expired(now_us, slot_opened[s])) begin
			slot_opened[s] = now_us;
			slot_hits[s] = '0;
			slot_flagged[s] = 1'b0;
		end
		slot_hits[s] = count_up(slot_hits[s]);

		// The identifier flood wins over the bus alert on the same frame.
		if (!slot_flagged[s] && slot_hits[s] > CNT_W'(id_limit)) begin
			slot_flagged[s] = 1'b1;
			want.kind = ALERT_ID_FLOOD;
			want.ident = ident;
			want.count = slot_hits[s];
			n_floods++;
		end else if (!bus_flagged && bus_hits > CNT_W'(bus_limit)) begin
			bus_flagged = 1'b1;
			want.kind = ALERT_BUS_SAT;
			want.ident = ident;
			want.count = bus_hits;
			n_sats++;
		end else begin
			want.kind = ALERT_NONE;
			want.ident = '0;
			want.count = '0;
		end
		alert_fifo.push_back(want);
		n_frames++;
	endtask

	task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	// Follow register writes, score alert beats, then predict for new frames.
	always @(posedge clk or negedge arst_n) begin
		int i;
		res_t want;
		if (!arst_n) begin
			window_ms = WINDOW_MS_RST;
			id_limit = PER_ID_THRESH_RST;
			bus_limit = TOTAL_THRESH_RST;
			for (i = 0; i < TABLE_ENTRIES; i++)
				slot_used[i] = 1'b0;
			bus_hits = '0;
			bus_opened = '0;
			bus_flagged = 1'b0;
			alert_fifo.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_WINDOW_MS:     window_ms = pwdata[CFG_W-1:0];
					REG_PER_ID_THRESH: id_limit = pwdata[CFG_W-1:0];
					REG_TOTAL_THRESH:  bus_limit = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (alert_valid && alert_ready) begin
				if (alert_fifo.size() == 0) begin
					n_fail++;
					$display("%0t ns: alert beat with nothing expected, got kind %0d ident %0d count %0d",
						$time, alert_kind, alert_ident, alert_count);
				end else begin
					want = alert_fifo.pop_front();
					check_field("alert_kind", 32'(want.kind), 32'(alert_kind));
					check_field("alert_ident", 32'(want.ident), 32'(alert_ident));
					check_field("alert_count", 32'(want.count), 32'(alert_count));
				end
			end
			if (frame_valid && frame_ready)
				score_frame(frame_ident, arrival_time_us);
			pending <= alert_fifo.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the CAN identifier flood rate monitor: stimulus, idling and verdict.
module tb;
	import cfrm_pkg::*;

	localparam int TABLE_ENTRIES = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * (TABLE_ENTRIES + 5);
	localparam int POOL_SIZE = 48;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 185;
	// Address one past the last register; writes there must be ignored.
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic frame_valid = 1'b0;
	logic frame_ready;
	logic [ID_W-1:0] frame_ident = '0;
	logic [TIME_W-1:0] arrival_time_us = '0;
	logic alert_valid;
	logic alert_ready = 1'b0;
	logic [1:0] alert_kind;
	logic [ID_W-1:0] alert_ident;
	logic [CNT_W-1:0] alert_count;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	logic calm = 1'b0;
	int fail_count;
	int pending;
	int frames_seen;
	int floods_seen;
	int sats_seen;
	int settings_used = 1;
	logic [CFG_W-1:0] cur_window = WINDOW_MS_RST;
	logic [TIME_W-1:0] now_us = '0;
	logic [ID_W-1:0] hot_ids [4];
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	always #1 clk = ~clk;

	can_id_flood_rate_monitor_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_ident(frame_ident),
		.arrival_time_us(arrival_time_us),
		.alert_valid(alert_valid),
		.alert_ready(alert_ready),
		.alert_kind(alert_kind),
		.alert_ident(alert_ident),
		.alert_count(alert_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	flood_alert_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_ident(frame_ident),
		.arrival_time_us(arrival_time_us),
		.alert_valid(alert_valid),
		.alert_ready(alert_ready),
		.alert_kind(alert_kind),
		.alert_ident(alert_ident),
		.alert_count(alert_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending),
		.frames_seen(frames_seen),
		.floods_seen(floods_seen),
		.sats_seen(sats_seen)
	);

	// The alert side stalls now and then, except during the calm phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_ready <= 1'b0;
		end else begin
			alert_ready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	// Present one frame beat, sometimes after an idle gap, and return at its accept edge.
	task automatic push_frame(input logic [ID_W-1:0] ident, input logic [TIME_W-1:0] stamp);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 11)
			gap = $urandom_range(1, 60);
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		frame_ident <= ident;
		arrival_time_us <= stamp;
		do @(posedge clk); while (!frame_ready);
	endtask

	// Drop the frame channel and wait until every predicted alert has come out.
	task automatic wait_drained();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Setup and access phase of one register write; the bus stays selected on return.
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= {(PDATA_W - CFG_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_WINDOW_MS)
			cur_window = value;
	endtask

	// Reprogram all three registers once the monitor is idle, optionally poking the unmapped address.
	task automatic program_settings(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] idt,
			input logic [CFG_W-1:0] tot, input logic poke_unmapped);
		wait_drained();
		write_reg(REG_WINDOW_MS, win);
		write_reg(REG_PER_ID_THRESH, idt);
		write_reg(REG_TOTAL_THRESH, tot);
		if (poke_unmapped)
			write_reg(REG_UNMAPPED, 16'hFFFF);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_used++;
	endtask

	// Four busy identifiers or a pool larger than the table for most picks, else anything.
	function automatic logic [ID_W-1:0] pick_ident();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return hot_ids[$urandom_range(0, 3)];
		if (r < 90)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		return ID_W'($urandom);
	endfunction

	// Time step between frames, scaled to the current window length.
	function automatic logic [TIME_W-1:0] pick_step();
		logic [31:0] span;
		int r;
		span = (cur_window == '0) ? 32'd1000 : 32'(cur_window) * 32'd1000;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 65)
			return TIME_W'($urandom_range(0, span / 8 + 1));
		if (r < 96)
			return TIME_W'($urandom_range(0, 2 * span));
		return TIME_W'({$urandom, $urandom});
	endfunction

	// Nothing accepted for too long means the monitor hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((frame_valid && frame_ready) || (alert_valid && alert_ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int k;
		int ph;
		int n;
		int r;
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] idt;
		logic [CFG_W-1:0] tot;
		logic [TIME_W-1:0] t0;

		hot_ids[0] = 11'h000;
		hot_ids[1] = 11'h7FF;
		for (k = 2; k < 4; k++)
			hot_ids[k] = ID_W'($urandom);
		for (k = 0; k < POOL_SIZE; k++)
			id_pool[k] = ID_W'($urandom);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: window edges, timestamp extremes and wrap-around.
		push_frame(11'h000, 48'h0);
		push_frame(11'h7FF, 48'd1000000);
		push_frame(11'h7FF, 48'd1000001);
		push_frame(11'h555, 48'hFFFF_FFFF_FFFF);
		push_frame(11'h2AA, 48'h0000_0000_0010);
		push_frame(11'h7FF, 48'hAAAA_AAAA_AAAA);
		push_frame(11'h000, 48'h5555_5555_5555);

		// Zero window and zero thresholds: every frame alerts, identifier flood first.
		program_settings(16'd0, 16'd0, 16'd0, 1'b1);
		t0 = 48'h5555_5555_6000;
		push_frame(11'h123, t0);
		push_frame(11'h123, t0);
		push_frame(11'h456, t0);
		push_frame(11'h123, t0 + 48'd1);
		push_frame(11'h123, t0 + 48'd1);

		// Largest window and thresholds: nothing may fire.
		program_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		push_frame(11'h001, 48'h0);
		push_frame(11'h001, 48'h8000_0000_0000);
		push_frame(11'h400, 48'h8000_0000_0001);
		push_frame(11'h001, 48'h8000_0000_0001);

		// Both counts cross on the same frame; the bus alert follows one frame later.
		program_settings(16'd2, 16'd3, 16'd3, 1'b0);
		for (k = 0; k < 6; k++)
			push_frame(11'h321, 48'h0000_1234_0000);

		// Random phases, each under its own settings.
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				win = 16'd1;
				idt = 16'd2;
				tot = 16'd10;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20)
					win = '0;
				else if (r < 70)
					win = CFG_W'($urandom_range(1, 5));
				else if (r < 85)
					win = CFG_W'($urandom_range(6, 50));
				else if (r < 95)
					win = 16'hFFFF;
				else
					win = CFG_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 70)
					idt = CFG_W'($urandom_range(0, 6));
				else if (r < 90)
					idt = CFG_W'($urandom_range(7, 40));
				else
					idt = 16'hFFFF;
				r = $urandom_range(0, 99);
				if (r < 70)
					tot = CFG_W'($urandom_range(0, 40));
				else if (r < 90)
					tot = CFG_W'($urandom_range(41, 300));
				else
					tot = 16'hFFFF;
			end
			program_settings(win, idt, tot, 1'b0);
			calm <= (ph == 1);
			if (ph == 2)
				now_us = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 20000));
			else
				now_us = TIME_W'({$urandom, $urandom});
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Once, let the alert side catch up completely in mid-phase.
				if (ph == 4 && n == PHASE_ITEMS / 2)
					wait_drained();
				now_us = now_us + pick_step();
				push_frame(pick_ident(), now_us);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d frames under %0d register settings, with gaps and stalls.",
			frames_seen, settings_used);
		$display("It predicted %0d identifier floods and %0d bus saturations; %0d mismatches.",
			floods_seen, sats_seen, fail_count);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cfrm_pkg.sv
hw/rtl/cfrm_slot_ram.sv
hw/rtl/cfrm_cfg_regs.sv
hw/rtl/cfrm_engine.sv
hw/rtl/can_id_flood_rate_monitor_core.sv
hw/rtl/cfrm_checker.sv
sim/flood_alert_checker.sv
sim/tb.sv
